// ===== design/ddr_pkg.sv =====
`default_nettype none
package ddr_pkg;
	localparam int MAX_MSG = 4095;
	localparam int CNT_W = 13;
	localparam int RESP_MAX = 19;
	localparam int IDX_W = 5;
	localparam logic [16:0] IDLE_SAT = 17'h1FFFF;

	localparam logic [2:0] REG_DID_VERSION = 3'd0;
	localparam logic [2:0] REG_DID_UPTIME = 3'd1;
	localparam logic [2:0] REG_DID_STATS = 3'd2;
	localparam logic [2:0] REG_DID_LED = 3'd3;
	localparam logic [2:0] REG_S3_LIMIT = 3'd4;

	localparam logic [7:0] SID_SESSION = 8'h10;
	localparam logic [7:0] SID_READ = 8'h22;
	localparam logic [7:0] SID_WRITE = 8'h2E;
	localparam logic [7:0] SID_FAULT = 8'h19;
	localparam logic [7:0] SID_PRESENT = 8'h3E;
	localparam logic [7:0] NEG_RESP = 8'h7F;
	localparam logic [7:0] NRC_NOT_SUPPORTED = 8'h11;
	localparam logic [7:0] NRC_SUB_NOT_SUPPORTED = 8'h12;
	localparam logic [7:0] NRC_CONDITIONS = 8'h22;
	localparam logic [7:0] NRC_OUT_OF_RANGE = 8'h31;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [31:0] tx_frames;
		logic [31:0] rx_frames;
		logic [31:0] tx_acked;
		logic [31:0] error_sum;
		logic        bus_off_seen;
		logic        passive_seen;
		logic        protocol_fault_seen;
	} req_t;

	typedef struct packed {
		logic [7:0] resp_byte;
		logic       resp_last;
		logic [7:0] led_level;
		logic       in_extended;
	} resp_t;

	typedef struct packed {
		logic [RESP_MAX-1:0][7:0] bytes;
		logic [IDX_W-1:0]         count;
		logic [7:0]               led_level;
		logic                     in_extended;
	} msg_t;

	function automatic logic [7:0] version_char(input logic [3:0] i);
		case (i)
			4'd0: version_char = 8'h47;
			4'd1: version_char = 8'h34;
			4'd2: version_char = 8'h37;
			4'd3: version_char = 8'h34;
			4'd4: version_char = 8'h2D;
			4'd5: version_char = 8'h43;
			4'd6: version_char = 8'h41;
			4'd7: version_char = 8'h4E;
			4'd8: version_char = 8'h20;
			4'd9: version_char = 8'h76;
			4'd10: version_char = 8'h33;
			4'd11: version_char = 8'h2E;
			4'd12: version_char = 8'h30;
			default: version_char = 8'h00;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== design/ddr_front.sv =====
`default_nettype none
module ddr_front import ddr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire req_t        in_data,
	output logic             msg_valid,
	output msg_t             msg,
	input  wire logic        msg_stall
);
	logic [15:0] did_version_q, did_uptime_q, did_stats_q, did_led_q, s3_limit_q;
	logic        ext_q;
	logic [16:0] idle_q;
	logic [9:0]  ms_q;
	logic [31:0] up_q;
	logic [3:0][7:0] head_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]  led_q;

	logic        acc;
	logic [1:0]  hidx;
	logic [3:0][7:0] h;
	logic [CNT_W-1:0] len;
	logic        serve;
	msg_t        m;
	logic        n_ext;
	logic [7:0]  n_led;
	logic        emit;
	logic [15:0] did;
	logic [6:0]  sub;
	logic [31:0] st [4];

	assign in_stall = msg_valid && msg_stall;
	assign acc = in_valid && !in_stall;
	assign hidx = cnt_q[1:0];
	assign len = cnt_q + CNT_W'(1);
	assign serve = !in_data.req_type && in_data.last_byte && cnt_q < CNT_W'(MAX_MSG);
	assign did = {h[1], h[2]};
	assign sub = h[1][6:0];
	assign st[0] = in_data.tx_frames;
	assign st[1] = in_data.rx_frames;
	assign st[2] = in_data.tx_acked;
	assign st[3] = in_data.error_sum;

	always_comb begin
		h = head_q;
		if (cnt_q < CNT_W'(4)) begin
			h[hidx] = in_data.data_byte;
		end
		m = '0;
		n_ext = ext_q;
		n_led = led_q;
		emit = 1'b1;
		m.bytes[0] = NEG_RESP;
		m.bytes[1] = h[0];
		m.bytes[2] = NRC_NOT_SUPPORTED;
		m.count = IDX_W'(3);
		case (h[0])
			SID_SESSION: begin
				if (len != CNT_W'(2)) begin
					m.bytes[2] = NRC_OUT_OF_RANGE;
				end else if (sub != 7'd1 && sub != 7'd3) begin
					m.bytes[2] = NRC_SUB_NOT_SUPPORTED;
				end else begin
					n_ext = (sub == 7'd3);
					m.bytes[0] = 8'h50;
					m.bytes[1] = {1'b0, sub};
					m.bytes[2] = 8'h00;
					m.bytes[3] = 8'h32;
					m.bytes[4] = 8'h01;
					m.bytes[5] = 8'hF4;
					m.count = IDX_W'(6);
				end
			end
			SID_READ: begin
				m.bytes[2] = NRC_OUT_OF_RANGE;
				if (len == CNT_W'(3)) begin
					if (did == did_version_q) begin
						m.bytes[0] = 8'h62;
						m.bytes[1] = h[1];
						m.bytes[2] = h[2];
						for (int i = 0; i < 13; i++) begin
							m.bytes[3+i] = version_char(4'(i));
						end
						m.count = IDX_W'(16);
					end else if (did == did_uptime_q) begin
						m.bytes[0] = 8'h62;
						m.bytes[1] = h[1];
						m.bytes[2] = h[2];
						for (int i = 0; i < 4; i++) begin
							m.bytes[3+i] = up_q[31-8*i -: 8];
						end
						m.count = IDX_W'(7);
					end else if (did == did_stats_q) begin
						m.bytes[0] = 8'h62;
						m.bytes[1] = h[1];
						m.bytes[2] = h[2];
						for (int j = 0; j < 4; j++) begin
							for (int i = 0; i < 4; i++) begin
								m.bytes[3+4*j+i] = st[j][31-8*i -: 8];
							end
						end
						m.count = IDX_W'(19);
					end else if (did == did_led_q) begin
						m.bytes[0] = 8'h62;
						m.bytes[1] = h[1];
						m.bytes[2] = h[2];
						m.bytes[3] = led_q;
						m.count = IDX_W'(4);
					end
				end
			end
			SID_WRITE: begin
				if (!ext_q) begin
					m.bytes[2] = NRC_CONDITIONS;
				end else if (len != CNT_W'(4) || did != did_led_q) begin
					m.bytes[2] = NRC_OUT_OF_RANGE;
				end else begin
					n_led = h[3];
					m.bytes[0] = 8'h6E;
					m.bytes[1] = h[1];
					m.bytes[2] = h[2];
				end
			end
			SID_FAULT: begin
				if (len != CNT_W'(3) || h[1] != 8'h01) begin
					m.bytes[2] = NRC_OUT_OF_RANGE;
				end else begin
					m.bytes[0] = 8'h59;
					m.bytes[1] = 8'h01;
					m.bytes[2] = 8'h01;
					m.bytes[3] = 8'hC1;
					m.bytes[4] = 8'h00;
					m.bytes[5] = {7'd0, in_data.bus_off_seen};
					m.bytes[6] = 8'hC1;
					m.bytes[7] = 8'h01;
					m.bytes[8] = {7'd0, in_data.passive_seen};
					m.bytes[9] = 8'hC1;
					m.bytes[10] = 8'h02;
					m.bytes[11] = {7'd0, in_data.protocol_fault_seen};
					m.count = IDX_W'(12);
				end
			end
			SID_PRESENT: begin
				if (len == CNT_W'(2) && sub == 7'd0) begin
					emit = !h[1][7];
					m.bytes[0] = 8'h7E;
					m.bytes[1] = 8'h00;
					m.count = IDX_W'(2);
				end else begin
					m.bytes[2] = NRC_SUB_NOT_SUPPORTED;
				end
			end
			default: begin
			end
		endcase
		m.led_level = n_led;
		m.in_extended = n_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			did_version_q <= 16'hF195;
			did_uptime_q <= 16'h0100;
			did_stats_q <= 16'h0101;
			did_led_q <= 16'h0102;
			s3_limit_q <= 16'd5000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DID_VERSION: did_version_q <= cfg_data;
				REG_DID_UPTIME: did_uptime_q <= cfg_data;
				REG_DID_STATS: did_stats_q <= cfg_data;
				REG_DID_LED: did_led_q <= cfg_data;
				REG_S3_LIMIT: s3_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !in_data.req_type && cnt_q < CNT_W'(4)) begin
			head_q[hidx] <= in_data.data_byte;
		end
		if (acc && serve) begin
			msg <= m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= 1'b0;
			idle_q <= '0;
			ms_q <= '0;
			up_q <= '0;
			cnt_q <= '0;
			led_q <= '0;
			msg_valid <= 1'b0;
		end else begin
			if (msg_valid && !msg_stall && !(acc && serve)) begin
				msg_valid <= 1'b0;
			end
			if (acc) begin
				if (in_data.req_type) begin
					if (ms_q == 10'd999) begin
						ms_q <= '0;
						up_q <= up_q + 32'd1;
					end else begin
						ms_q <= ms_q + 10'd1;
					end
					if (idle_q != IDLE_SAT) begin
						idle_q <= idle_q + 17'd1;
					end
					if ((idle_q != IDLE_SAT ? idle_q + 17'd1 : idle_q) > {1'b0, s3_limit_q}) begin
						ext_q <= 1'b0;
					end
				end else if (!in_data.last_byte) begin
					if (cnt_q != CNT_W'(MAX_MSG + 1)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end else begin
					cnt_q <= '0;
					if (serve) begin
						idle_q <= '0;
						ext_q <= n_ext;
						led_q <= n_led;
						msg_valid <= emit;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/ddr_back.sv =====
`default_nettype none
module ddr_back import ddr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic msg_valid,
	input  wire msg_t msg,
	output logic      msg_stall,
	output logic      out_valid,
	output resp_t     out_data,
	input  wire logic stall
);
	msg_t             cur_q;
	logic             busy_q;
	logic [IDX_W-1:0] pos_q;
	logic             adv;
	logic             done;

	assign adv = !out_valid || !stall;
	assign done = busy_q && pos_q + IDX_W'(1) == cur_q.count;
	assign msg_stall = busy_q && !(adv && done);

	always_ff @(posedge clk) begin
		if (msg_valid && !msg_stall) begin
			cur_q <= msg;
		end
		if (adv && busy_q) begin
			out_data.resp_byte <= cur_q.bytes[pos_q];
			out_data.resp_last <= done;
			out_data.led_level <= cur_q.led_level;
			out_data.in_extended <= cur_q.in_extended;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (adv) begin
				out_valid <= busy_q;
			end
			if (msg_valid && !msg_stall) begin
				busy_q <= 1'b1;
				pos_q <= '0;
			end else if (adv && busy_q) begin
				pos_q <= done ? '0 : pos_q + IDX_W'(1);
				if (done) begin
					busy_q <= 1'b0;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/diagnostic_request_responder.sv =====
// Diagnostic request responder.
// Input channel (in_valid, in_stall, in_data): one transaction per cycle
// unless stalled, either a request byte or a one millisecond tick. Request
// bytes collect until last_byte; the front part then builds the full reply.
// A one-entry message register parts the front from the back part, which
// sends the reply one byte per transaction on (out_valid, stall, out_data).
// The first reply byte passes through the message register, the back
// part's current-message register and the output register. The input
// stalls only while a finished reply waits in the message register and
// the back part is still sending an earlier reply.
// Configuration: cfg_we, cfg_index, cfg_data write one register per cycle.
// Reset clears sessions, timers, counters and LED level and restores the
// default identifiers; no clearing pass is needed.
// A stalled receiver freezes out_data and, once the message register is
// full, backs up to in_stall.
`default_nettype none
module diagnostic_request_responder import ddr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire req_t        in_data,
	output logic             out_valid,
	output resp_t            out_data,
	input  wire logic        stall
);
	logic msg_valid;
	logic msg_stall;
	msg_t msg;

	ddr_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .in_data,
		.msg_valid, .msg, .msg_stall
	);

	ddr_back u_back (
		.clk, .arst_n, .msg_valid, .msg, .msg_stall,
		.out_valid, .out_data, .stall
	);
endmodule
`default_nettype wire

// ===== design/ddr_checker.sv =====
`default_nettype none
module ddr_checker import ddr_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  in_stall,
	input wire logic  out_valid,
	input wire resp_t out_data,
	input wire logic  stall
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stall |=> out_valid && $stable(out_data))
		else $error("output changed under stall");
	a_stall_backed: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> out_valid)
		else $error("input stalled with no reply under way");
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid after reset");
	a_led_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stall && !out_data.resp_last ##1 out_valid
		|-> out_data.led_level == $past(out_data.led_level))
		else $error("led level changed within a reply");
endmodule

bind diagnostic_request_responder ddr_checker u_checker (
	.clk, .arst_n, .in_stall, .out_valid, .out_data, .stall
);
`default_nettype wire
